[design/fhq_pkg.sv]
package fhq_pkg;

	// Default store sizes
	localparam int DEF_MAX_TRIANGLES = 1024;
	localparam int DEF_MAX_OBJECTS   = 256;

	// Field widths of the transaction payloads
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 10;
	localparam int CORNER_W = 2;
	localparam int OBJ_W    = 8;
	localparam int COORD_W  = 32;
	localparam int REACH_W  = 31;
	localparam int NMIN_W   = 17;
	localparam int S_DATA_W = 184;
	localparam int M_DATA_W = 136;

	// Arithmetic widths
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int EDGE_W   = PROD_W + 1;
	localparam int NPROD_W  = COORD_W + DIFF_W;
	localparam int NUM_W    = NPROD_W + 1;
	localparam int DIV_BITS = NUM_W - 1;
	localparam int DEN_W    = COORD_W - 1;
	localparam int QSAT_W   = 63;
	localparam int Y_W      = 64;
	localparam int WIN_W    = COORD_W + 2;

	// Inside-test epsilon (0.001 in Q16.16) and register reset value
	localparam int EPS_Q            = 66;
	localparam int NORMAL_MIN_RESET = 45875;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WR_TRI    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET_SOLID = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

	// Corner code that selects the normal
	localparam logic [CORNER_W-1:0] CORNER_NORMAL = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_LOAD  = 5'b10000
	} fhq_state_t;

endpackage

[design/floor_height_query.sv]
// Floor height query over a store of collision triangles. Write transactions
// (tuser op 0 and 1) are taken back to back while idle and load a triangle
// word, its tag and in-use mark, or an object's solid bit. A query transaction
// (op 2) scans every triangle slot, one slot per cycle from the triangle
// memories, through the edge test, the plane-height numerator and a 65-stage
// pipelined divider, and offers its single result once the pipeline has
// drained; the next transaction is taken once the result is loaded into the
// output register. After reset a clearing pass over the slots and objects
// empties the in-use marks and makes every object solid; no transaction is
// taken during it, configuration writes are. A result with found low carries
// zeros in every other field.
module floor_height_query
	import fhq_pkg::*;
#(
	parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
	parameter int MAX_OBJECTS   = DEF_MAX_OBJECTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// slot, corner, object_id, coord_x, coord_y, coord_z, entry_valid,
	// solid_flag, reach_above, reach_below, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// op
	input  logic [OP_W-1:0]     s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// floor_height, hit_normal_x, hit_normal_y, hit_normal_z, hit_object
	output logic [M_DATA_W-1:0] m_tdata,
	// found
	output logic                m_tuser,
	input  logic                cfg_wr_en,
	input  logic [NMIN_W-1:0]   cfg_wr_data
);

	localparam int TRI_AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int OBJ_AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int CLR_N  = (MAX_TRIANGLES > MAX_OBJECTS) ? MAX_TRIANGLES : MAX_OBJECTS;
	localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
	localparam int VW     = 3 * COORD_W;
	localparam int TAG_W  = OBJ_W + 1;
	localparam logic signed [EDGE_W-1:0] EDGE_LO = EDGE_W'(-EPS_Q * 65536);
	localparam logic signed [EDGE_W-1:0] EDGE_HI = EDGE_W'((EPS_Q + 1) * 65536);
	localparam logic [DIV_BITS-1:0] QSAT = DIV_BITS'(1) << 62;
	localparam logic signed [Y_W-1:0] Y_MAX32 = Y_W'(32'sh7fffffff);
	localparam logic signed [Y_W-1:0] Y_MIN32 = -Y_W'(64'sh80000000);

	fhq_state_t state_q;

	// Input field unpack
	logic [SLOT_W-1:0]         in_slot;
	logic [CORNER_W-1:0]       in_corner;
	logic [OBJ_W-1:0]          in_obj;
	logic signed [COORD_W-1:0] in_x, in_y, in_z;
	logic                      in_ev, in_sf;
	logic [REACH_W-1:0]        in_ra, in_rb;
	logic                      s_acc;
	logic                      slot_ok, obj_ok;
	logic [15:0]               slot_ext, obj_ext;

	// Configuration and query registers
	logic [NMIN_W-1:0]         nmin_q;
	logic signed [COORD_W-1:0] qx_q, qz_q;
	logic signed [WIN_W-1:0]   hi_q, lo_q;
	logic [TRI_AW-1:0]         scan_q;
	logic [CLR_W-1:0]          clr_q;
	logic                      clr_tri, clr_obj;

	// Memory ports
	logic                v_we [3];
	logic                n_we, t_we, o_we;
	logic [TRI_AW-1:0]   t_waddr, raddr;
	logic [TAG_W-1:0]    t_wdata, t_rd;
	logic [OBJ_AW-1:0]   o_waddr, o_raddr;
	logic                o_wdata, o_rd;
	logic [VW-1:0]       v_rd [3];
	logic [VW-1:0]       n_rd;
	logic [15:0]         tag_ext;

	// Scan pipeline
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [TRI_AW-1:0]         slot_s1, slot_s2, slot_s3, slot_s4, slot_s5;
	logic signed [DIFF_W-1:0]  ex_s2 [3];
	logic signed [DIFF_W-1:0]  ez_s2 [3];
	logic signed [DIFF_W-1:0]  px_s2 [3];
	logic signed [DIFF_W-1:0]  pz_s2 [3];
	logic signed [COORD_W-1:0] nx_s2, ny_s2, nz_s2, v0y_s2, v0y_s3, v0y_s4;
	logic                      use_s2, oor_s2;
	logic signed [PROD_W-1:0]  p_s3 [3];
	logic signed [PROD_W-1:0]  q_s3 [3];
	logic signed [NPROD_W-1:0] npx_s3, npz_s3;
	logic [DEN_W-1:0]          den_s3, den_s4;
	logic                      live_s3, cand_s4, cand_s5;
	logic signed [EDGE_W-1:0]  edge_e [3];
	logic                      negs, poss;
	logic signed [NUM_W-1:0]   num_s4;
	logic signed [Y_W-1:0]     y_s5;

	// Divider stages
	logic                      dv_v_s    [0:DIV_BITS];
	logic [DEN_W-1:0]          dv_rem_s  [0:DIV_BITS];
	logic [DIV_BITS-1:0]       dv_dq_s   [0:DIV_BITS];
	logic [DEN_W-1:0]          dv_den_s  [0:DIV_BITS];
	logic                      dv_neg_s  [0:DIV_BITS];
	logic                      dv_cand_s [0:DIV_BITS];
	logic signed [COORD_W-1:0] dv_v0y_s  [0:DIV_BITS];
	logic [TRI_AW-1:0]         dv_slot_s [0:DIV_BITS];
	logic [DIV_BITS-1:0]       q_fin;
	logic [QSAT_W-1:0]         q_sat;
	logic                      div_busy, busy;

	// Best candidate and output
	logic                      found_q;
	logic signed [Y_W-1:0]     best_q;
	logic [TRI_AW-1:0]         best_slot_q;
	logic                      take;
	logic signed [COORD_W-1:0] fh32;
	logic                      m_tvalid_q;
	logic [M_DATA_W-1:0]       m_tdata_q;
	logic                      m_tuser_q;

	// Unpack the input transaction
	assign in_slot   = s_tdata[9:0];
	assign in_corner = s_tdata[11:10];
	assign in_obj    = s_tdata[19:12];
	assign in_x      = s_tdata[51:20];
	assign in_y      = s_tdata[83:52];
	assign in_z      = s_tdata[115:84];
	assign in_ev     = s_tdata[116];
	assign in_sf     = s_tdata[117];
	assign in_ra     = s_tdata[148:118];
	assign in_rb     = s_tdata[179:149];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign slot_ext = {6'b0, in_slot};
	assign obj_ext  = {8'b0, in_obj};
	assign slot_ok  = 17'(in_slot) < 17'(MAX_TRIANGLES);
	assign obj_ok   = 17'(in_obj) < 17'(MAX_OBJECTS);
	assign clr_tri  = (CLR_W + 1)'(clr_q) < (CLR_W + 1)'(MAX_TRIANGLES);
	assign clr_obj  = (CLR_W + 1)'(clr_q) < (CLR_W + 1)'(MAX_OBJECTS);

	// Steer the write ports: clearing pass or a write transaction
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v_we[k] = s_acc && (s_tuser == OP_WR_TRI) && slot_ok
				&& (in_corner == CORNER_W'(k));
		end
		n_we = s_acc && (s_tuser == OP_WR_TRI) && slot_ok && (in_corner == CORNER_NORMAL);
		if (state_q == ST_CLEAR) begin
			t_we    = clr_tri;
			t_waddr = clr_q[TRI_AW-1:0];
			t_wdata = '0;
			o_we    = clr_obj;
			o_waddr = clr_q[OBJ_AW-1:0];
			o_wdata = 1'b1;
		end else begin
			t_we    = s_acc && (s_tuser == OP_WR_TRI) && slot_ok;
			t_waddr = slot_ext[TRI_AW-1:0];
			t_wdata = {in_ev, in_obj};
			o_we    = s_acc && (s_tuser == OP_SET_SOLID) && obj_ok;
			o_waddr = obj_ext[OBJ_AW-1:0];
			o_wdata = in_sf;
		end
	end

	assign raddr   = (state_q == ST_SCAN) ? scan_q : best_slot_q;
	assign tag_ext = {8'b0, t_rd[OBJ_W-1:0]};
	assign o_raddr = tag_ext[OBJ_AW-1:0];

	for (genvar k = 0; k < 3; k++) begin : g_vtx
		fhq_ram #(.WIDTH(VW), .DEPTH(MAX_TRIANGLES)) u_vtx (
			.clk   (clk),
			.we    (v_we[k]),
			.waddr (slot_ext[TRI_AW-1:0]),
			.wdata ({in_z, in_y, in_x}),
			.raddr (raddr),
			.rdata (v_rd[k])
		);
	end

	fhq_ram #(.WIDTH(VW), .DEPTH(MAX_TRIANGLES)) u_nrm (
		.clk   (clk),
		.we    (n_we),
		.waddr (slot_ext[TRI_AW-1:0]),
		.wdata ({in_z, in_y, in_x}),
		.raddr (raddr),
		.rdata (n_rd)
	);

	fhq_ram #(.WIDTH(TAG_W), .DEPTH(MAX_TRIANGLES)) u_tag (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (raddr),
		.rdata (t_rd)
	);

	fhq_ram #(.WIDTH(1), .DEPTH(MAX_OBJECTS)) u_solid (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rd)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmin_q <= NMIN_W'(NORMAL_MIN_RESET);
		end else if (cfg_wr_en) begin
			nmin_q <= cfg_wr_data;
		end
	end

	// Sequence clearing, scan and result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					scan_q <= '0;
					if (s_acc && s_tuser == OP_QUERY) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == TRI_AW'(MAX_TRIANGLES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Hold the query point and height window
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == OP_QUERY) begin
			qx_q <= in_x;
			qz_q <= in_z;
			hi_q <= WIN_W'(in_y) + WIN_W'($signed({1'b0, in_ra}));
			lo_q <= WIN_W'(in_y) - WIN_W'($signed({1'b0, in_rb}));
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			dv_v_s[0] <= v_s4;
			v_s5 <= dv_v_s[DIV_BITS];
		end
	end

	// Stage 1 to 2: take differences of vertex and point coordinates
	always_ff @(posedge clk) begin
		slot_s1 <= scan_q;
		slot_s2 <= slot_s1;
		for (int k = 0; k < 3; k++) begin
			ex_s2[k] <= DIFF_W'($signed(v_rd[(k + 1) % 3][31:0]))
				- DIFF_W'($signed(v_rd[k][31:0]));
			ez_s2[k] <= DIFF_W'($signed(v_rd[(k + 1) % 3][95:64]))
				- DIFF_W'($signed(v_rd[k][95:64]));
			px_s2[k] <= DIFF_W'(qx_q) - DIFF_W'($signed(v_rd[k][31:0]));
			pz_s2[k] <= DIFF_W'(qz_q) - DIFF_W'($signed(v_rd[k][95:64]));
		end
		nx_s2  <= n_rd[31:0];
		ny_s2  <= n_rd[63:32];
		nz_s2  <= n_rd[95:64];
		v0y_s2 <= v_rd[0][63:32];
		use_s2 <= t_rd[OBJ_W];
		oor_s2 <= 17'(t_rd[OBJ_W-1:0]) >= 17'(MAX_OBJECTS);
	end

	// Stage 2 to 3: multiply edge and numerator terms, check the slot
	always_ff @(posedge clk) begin
		slot_s3 <= slot_s2;
		for (int k = 0; k < 3; k++) begin
			p_s3[k] <= ex_s2[k] * pz_s2[k];
			q_s3[k] <= ez_s2[k] * px_s2[k];
		end
		npx_s3  <= nx_s2 * px_s2[0];
		npz_s3  <= nz_s2 * pz_s2[0];
		den_s3  <= ny_s2[DEN_W-1:0];
		v0y_s3  <= v0y_s2;
		live_s3 <= use_s2 && (oor_s2 || o_rd) && (ny_s2 > 0)
			&& (ny_s2 >= $signed(32'(nmin_q)));
	end

	// Stage 3: edge sums against the epsilon band
	always_comb begin
		negs = 1'b0;
		poss = 1'b0;
		for (int k = 0; k < 3; k++) begin
			edge_e[k] = EDGE_W'(p_s3[k]) - EDGE_W'(q_s3[k]);
			if (edge_e[k] < EDGE_LO) negs = 1'b1;
			if (edge_e[k] >= EDGE_HI) poss = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		slot_s4 <= slot_s3;
		num_s4  <= NUM_W'(npx_s3) + NUM_W'(npz_s3);
		den_s4  <= den_s3;
		v0y_s4  <= v0y_s3;
		cand_s4 <= live_s3 && !(negs && poss);
	end

	// Divider input: magnitude of the numerator
	always_ff @(posedge clk) begin
		dv_rem_s[0]  <= '0;
		dv_dq_s[0]   <= DIV_BITS'(num_s4[NUM_W-1] ? -num_s4 : num_s4);
		dv_den_s[0]  <= den_s4;
		dv_neg_s[0]  <= num_s4[NUM_W-1];
		dv_cand_s[0] <= cand_s4;
		dv_v0y_s[0]  <= v0y_s4;
		dv_slot_s[0] <= slot_s4;
	end

	// One quotient bit per stage
	for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
		logic [DEN_W:0] r2;
		logic           ge;

		assign r2 = {dv_rem_s[i], dv_dq_s[i][DIV_BITS-1]};
		assign ge = r2 >= {1'b0, dv_den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i+1] <= 1'b0;
			end else begin
				dv_v_s[i+1] <= dv_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[i+1]  <= ge ? DEN_W'(r2 - {1'b0, dv_den_s[i]}) : r2[DEN_W-1:0];
			dv_dq_s[i+1]   <= {dv_dq_s[i][DIV_BITS-2:0], ge};
			dv_den_s[i+1]  <= dv_den_s[i];
			dv_neg_s[i+1]  <= dv_neg_s[i];
			dv_cand_s[i+1] <= dv_cand_s[i];
			dv_v0y_s[i+1]  <= dv_v0y_s[i];
			dv_slot_s[i+1] <= dv_slot_s[i];
		end
	end

	// Saturate the quotient and form the plane height
	assign q_fin = dv_dq_s[DIV_BITS];
	assign q_sat = (q_fin > QSAT) ? QSAT[QSAT_W-1:0] : q_fin[QSAT_W-1:0];

	always_ff @(posedge clk) begin
		slot_s5 <= dv_slot_s[DIV_BITS];
		cand_s5 <= dv_cand_s[DIV_BITS];
		y_s5    <= dv_neg_s[DIV_BITS]
			? Y_W'(dv_v0y_s[DIV_BITS]) + Y_W'($signed({1'b0, q_sat}))
			: Y_W'(dv_v0y_s[DIV_BITS]) - Y_W'($signed({1'b0, q_sat}));
	end

	always_comb begin
		div_busy = 1'b0;
		for (int i = 0; i <= DIV_BITS; i++) begin
			div_busy = div_busy | dv_v_s[i];
		end
	end

	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || div_busy;

	// Keep the highest height in the window; lower slots win ties
	assign take = v_s5 && cand_s5 && (y_s5 <= Y_W'(hi_q)) && (y_s5 >= Y_W'(lo_q))
		&& (!found_q || y_s5 > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (s_acc && s_tuser == OP_QUERY) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q      <= y_s5;
			best_slot_q <= slot_s5;
		end
	end

	assign fh32 = (best_q > Y_MAX32) ? 32'sh7fffffff
		: (best_q < Y_MIN32) ? 32'sh80000000 : best_q[31:0];

	// Output register: load the result, drop it on a completed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_LOAD && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && (!m_tvalid_q || m_tready)) begin
			m_tuser_q <= found_q;
			m_tdata_q <= found_q ? {t_rd[OBJ_W-1:0], n_rd, fh32} : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	// No slot may be in flight outside a scan
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_LOAD) |-> !busy)
		else $error("scan pipeline busy outside scan");

	// Stores stay untouched while a query runs
	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !(t_we || o_we || n_we))
		else $error("store written during a query");

	// A result appears only from the load state
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_LOAD))
		else $error("result without a finished query");

	// The kept height always lies inside the window
	a_best_win: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q <= Y_W'(hi_q)) && (best_q >= Y_W'(lo_q)))
		else $error("kept height outside the window");

	// Scan stops at the last slot
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_q == TRI_AW'(MAX_TRIANGLES - 1)) |=> state_q == ST_DRAIN)
		else $error("scan ran past the last slot");
`endif

endmodule

[design/fhq_ram.sv]
module fhq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/floor_height_query_test.sv]
`timescale 1ns / 100ps

module floor_height_query_test;
	import fhq_pkg::*;

	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
	localparam int NSLOTS = DEF_MAX_TRIANGLES;
	localparam int NOBJS = DEF_MAX_OBJECTS;
	localparam int UNIT = 65536;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [SLOT_W-1:0]    slot;
		logic [CORNER_W-1:0]  corner;
		logic [OBJ_W-1:0]     obj;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic                 ev;
		logic                 sf;
		logic [REACH_W-1:0]   ra;
		logic [REACH_W-1:0]   rb;
	} txn_t;

	localparam int TXN_W = $bits(txn_t);

	typedef struct packed {
		logic                found;
		logic [COORD_W-1:0]  height;
		logic [COORD_W-1:0]  nx;
		logic [COORD_W-1:0]  ny;
		logic [COORD_W-1:0]  nz;
		logic [OBJ_W-1:0]    obj;
	} floor_hit_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [OP_W-1:0]     s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_wr_en;
	logic [NMIN_W-1:0]   cfg_wr_data;

	floor_height_query dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	// Predictor copy of the triangle store
	logic signed [31:0] vx_mem [NSLOTS][3];
	logic signed [31:0] vy_mem [NSLOTS][3];
	logic signed [31:0] vz_mem [NSLOTS][3];
	logic signed [31:0] nx_mem [NSLOTS];
	logic signed [31:0] ny_mem [NSLOTS];
	logic signed [31:0] nz_mem [NSLOTS];
	logic [OBJ_W-1:0]   tag_mem [NSLOTS];
	logic               in_use [NSLOTS];
	logic               solid [NOBJS];
	logic [NMIN_W-1:0]  normal_min;

	// Words already generated per slot, so no in-use slot reads an unwritten word
	logic [3:0] gen_words [NSLOTS];

	txn_t       txn_q [$];
	floor_hit_t floor_expect_q [$];
	int         errors;
	int         gap;
	int         m_stall;
	logic       s_fire;
	bit         no_idle;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
		errors++;
	endtask

	// Append one transaction to the pending queue
	task automatic enqueue_txn(txn_t t);
		txn_q.insert(txn_q.size(), t);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [S_DATA_W-1:0] pack_txn(txn_t t);
		return {4'b0, t.rb, t.ra, t.sf, t.ev, t.z, t.y, t.x, t.obj, t.corner, t.slot};
	endfunction

	// Work out the floor hit of one query
	function automatic floor_hit_t find_floor(txn_t t);
		floor_hit_t hit;
		wide_t      e, num, q, y, best, top, bottom;
		wide_t      lo_th, hi_th, qsat;
		longint     px, pz, ny, dx, dz;
		bit         negs, poss, found;
		int         best_slot, j;
		lo_th = -wide_t'(EPS_Q) * UNIT;
		hi_th = wide_t'(EPS_Q + 1) * UNIT;
		qsat = wide_t'(1) <<< 62;
		px = longint'(signed'(t.x));
		pz = longint'(signed'(t.z));
		top = wide_t'(longint'(signed'(t.y)) + longint'(t.ra));
		bottom = wide_t'(longint'(signed'(t.y)) - longint'(t.rb));
		found = 0;
		best = 0;
		best_slot = 0;
		for (int s = 0; s < NSLOTS; s++) begin
			if (!in_use[s] || !solid[tag_mem[s]]) continue;
			ny = longint'(ny_mem[s]);
			if (ny <= 0 || ny < longint'(normal_min)) continue;
			negs = 0;
			poss = 0;
			for (int k = 0; k < 3; k++) begin
				j = (k == 2) ? 0 : k + 1;
				dx = longint'(vx_mem[s][j]) - longint'(vx_mem[s][k]);
				dz = longint'(vz_mem[s][j]) - longint'(vz_mem[s][k]);
				e = wide_t'(dx) * wide_t'(pz - longint'(vz_mem[s][k]))
					- wide_t'(dz) * wide_t'(px - longint'(vx_mem[s][k]));
				if (e < lo_th) negs = 1;
				if (e >= hi_th) poss = 1;
			end
			if (negs && poss) continue;
			num = wide_t'(longint'(nx_mem[s])) * wide_t'(px - longint'(vx_mem[s][0]))
				+ wide_t'(longint'(nz_mem[s])) * wide_t'(pz - longint'(vz_mem[s][0]));
			q = num / wide_t'(ny);
			if (q > qsat) q = qsat;
			if (q < -qsat) q = -qsat;
			y = wide_t'(longint'(vy_mem[s][0])) - q;
			if (y > top || y < bottom) continue;
			if (!found || y > best) begin
				found = 1;
				best = y;
				best_slot = s;
			end
		end
		hit = '0;
		if (found) begin
			if (best > wide_t'(32'sh7fffffff)) best = wide_t'(32'sh7fffffff);
			if (best < -wide_t'(64'sh80000000)) best = -wide_t'(64'sh80000000);
			hit.found = 1;
			hit.height = best[31:0];
			hit.nx = nx_mem[best_slot];
			hit.ny = ny_mem[best_slot];
			hit.nz = nz_mem[best_slot];
			hit.obj = tag_mem[best_slot];
		end
		return hit;
	endfunction

	// Update the store copy with one accepted transaction
	task automatic apply_txn(txn_t t);
		case (t.op)
			OP_WR_TRI: begin
				if (t.corner == CORNER_NORMAL) begin
					nx_mem[t.slot] = t.x;
					ny_mem[t.slot] = t.y;
					nz_mem[t.slot] = t.z;
				end else begin
					vx_mem[t.slot][t.corner] = t.x;
					vy_mem[t.slot][t.corner] = t.y;
					vz_mem[t.slot][t.corner] = t.z;
				end
				tag_mem[t.slot] = t.obj;
				in_use[t.slot] = t.ev;
			end
			OP_SET_SOLID: solid[t.obj] = t.sf;
			OP_QUERY: floor_expect_q.insert(floor_expect_q.size(), find_floor(t));
			default: ;
		endcase
	endtask

	// Driver: present pending transactions with random gaps, stall results at random
	always @(negedge clk) begin
		txn_t t;
		if (arst_n) begin
			if (!s_tvalid || s_fire) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (txn_q.size() > 0) begin
					t = txn_q.pop_front();
					s_tdata <= pack_txn(t);
					s_tuser <= t.op;
					s_tvalid <= 1'b1;
					if ($urandom_range(0, 99) < 4) no_idle = !no_idle;
					gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (m_stall > 0) begin
				m_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				m_stall = pick_gap();
			end
		end
	end

	// Monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		txn_t       t;
		floor_hit_t want;
		s_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			{t.rb, t.ra, t.sf, t.ev, t.z, t.y, t.x, t.obj, t.corner, t.slot} =
				s_tdata[179:0];
			t.op = s_tuser;
			apply_txn(t);
		end
		if (m_tvalid && m_tready) begin
			if (floor_expect_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
			end else begin
				want = floor_expect_q.pop_front();
				if (m_tuser !== want.found) report_mismatch("found", m_tuser, want.found);
				if (m_tdata[31:0] !== want.height)
					report_mismatch("floor_height", m_tdata[31:0], want.height);
				if (m_tdata[63:32] !== want.nx)
					report_mismatch("hit_normal_x", m_tdata[63:32], want.nx);
				if (m_tdata[95:64] !== want.ny)
					report_mismatch("hit_normal_y", m_tdata[95:64], want.ny);
				if (m_tdata[127:96] !== want.nz)
					report_mismatch("hit_normal_z", m_tdata[127:96], want.nz);
				if (m_tdata[135:128] !== want.obj)
					report_mismatch("hit_object", m_tdata[135:128], want.obj);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		int idle_cycles;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int rand_coord(int span);
		if ($urandom_range(0, 19) == 0) return int'($urandom());
		return int'($urandom_range(0, 2 * span * UNIT)) - span * UNIT;
	endfunction

	function automatic int rand_reach();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return int'($urandom() >> 1);
		if (r == 1) return 0;
		return $urandom_range(0, 8 * UNIT);
	endfunction

	// Queue one triangle word; mark it in use only once all words exist
	task automatic push_word(int slot, int corner, int obj, int x, int y, int z, bit keep);
		txn_t t;
		t.op = OP_WR_TRI;
		t.slot = SLOT_W'(slot);
		t.corner = CORNER_W'(corner);
		t.obj = OBJ_W'(obj);
		t.x = x;
		t.y = y;
		t.z = z;
		gen_words[slot][corner] = 1'b1;
		t.ev = keep && (gen_words[slot] == 4'hf);
		t.sf = 1'($urandom());
		t.ra = REACH_W'($urandom());
		t.rb = REACH_W'($urandom());
		enqueue_txn(t);
	endtask

	task automatic push_triangle(int slot, int obj, int ax, int ay, int az, int bx, int by,
			int bz, int cx, int cy, int cz, int nx, int ny, int nz);
		push_word(slot, 0, obj, ax, ay, az, 1);
		push_word(slot, 1, obj, bx, by, bz, 1);
		push_word(slot, 2, obj, cx, cy, cz, 1);
		push_word(slot, CORNER_NORMAL, obj, nx, ny, nz, 1);
	endtask

	task automatic push_query(int x, int y, int z, int ra, int rb);
		txn_t t;
		t = txn_t'(TXN_W'($urandom()));
		t.slot = SLOT_W'($urandom());
		t.obj = OBJ_W'($urandom());
		t.op = OP_QUERY;
		t.x = x;
		t.y = y;
		t.z = z;
		t.ra = REACH_W'(ra);
		t.rb = REACH_W'(rb);
		enqueue_txn(t);
	endtask

	task automatic push_solid(int obj, bit flag);
		txn_t t;
		t = '0;
		t.op = OP_SET_SOLID;
		t.obj = OBJ_W'(obj);
		t.sf = flag;
		t.x = $urandom();
		t.y = $urandom();
		t.z = $urandom();
		enqueue_txn(t);
	endtask

	function automatic int rand_normal_y();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(30000, UNIT);
		if (r < 17) return $urandom_range(0, 30000);
		if (r < 19) return -int'($urandom_range(0, UNIT));
		return int'($urandom());
	endfunction

	// Random mix: mostly whole triangles and queries over a small area
	task automatic push_random(int count);
		int n, r, slot, obj, cx, cz;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NSLOTS - 1)
				: $urandom_range(0, 47);
			obj = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NOBJS - 1)
				: $urandom_range(0, 7);
			if (r < 40) begin
				cx = rand_coord(8);
				cz = rand_coord(8);
				push_triangle(slot, obj,
					cx + rand_coord(6), rand_coord(4), cz + rand_coord(6),
					cx + rand_coord(6), rand_coord(4), cz + rand_coord(6),
					cx + rand_coord(6), rand_coord(4), cz + rand_coord(6),
					int'($urandom_range(0, 80000)) - 40000, rand_normal_y(),
					int'($urandom_range(0, 80000)) - 40000);
				n += 4;
			end else if (r < 55) begin
				push_word(slot, $urandom_range(0, 3), obj, rand_coord(10), rand_coord(10),
					rand_coord(10), $urandom_range(0, 3) != 0);
				n++;
			end else if (r < 63) begin
				push_solid(obj, $urandom_range(0, 2) != 0);
				n++;
			end else if (r < 65) begin
				enqueue_txn(txn_t'({OP_IGNORED, (TXN_W - OP_W)'($urandom())}));
			end else begin
				push_query(rand_coord(10), rand_coord(6), rand_coord(10),
					rand_reach(), rand_reach());
				n++;
			end
		end
	endtask

	// Wait until the block is idle and every result has arrived
	task automatic wait_idle();
		while (txn_q.size() > 0 || s_tvalid || floor_expect_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_normal_min(int value);
		wait_idle();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = NMIN_W'(value);
		normal_min = NMIN_W'(value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_fire = 1'b0;
		errors = 0;
		gap = 0;
		m_stall = 0;
		no_idle = 0;
		normal_min = NORMAL_MIN_RESET;
		for (int s = 0; s < NSLOTS; s++) begin
			in_use[s] = 0;
			tag_mem[s] = 0;
			gen_words[s] = 0;
			nx_mem[s] = 0;
			ny_mem[s] = 0;
			nz_mem[s] = 0;
			for (int k = 0; k < 3; k++) begin
				vx_mem[s][k] = 0;
				vy_mem[s][k] = 0;
				vz_mem[s][k] = 0;
			end
		end
		for (int o = 0; o < NOBJS; o++) solid[o] = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: flat floor at height one, found exactly at the lower bound
		push_triangle(0, 1, -4 * UNIT, UNIT, -4 * UNIT, 4 * UNIT, UNIT, -4 * UNIT,
			0, UNIT, 4 * UNIT, 0, UNIT, 0);
		push_query(0, 2 * UNIT, 0, 0, UNIT);
		push_query(0, 2 * UNIT, 0, 0, UNIT - 1);
		push_query(9 * UNIT, 2 * UNIT, 0, 0, 4 * UNIT);
		// Tie at equal height: the lower slot wins
		push_triangle(1023, 255, -4 * UNIT, UNIT, -4 * UNIT, 4 * UNIT, UNIT, -4 * UNIT,
			0, UNIT, 4 * UNIT, 0, UNIT, 0);
		push_query(0, 0, 0, 32'h7fffffff, 32'h7fffffff);
		// Hidden object, then solid again
		push_solid(1, 0);
		push_query(0, 0, 0, 32'h7fffffff, 0);
		push_solid(1, 1);
		// Flat and downward normals are never floors
		push_triangle(2, 3, -4 * UNIT, 3 * UNIT, -4 * UNIT, 4 * UNIT, 3 * UNIT, -4 * UNIT,
			0, 3 * UNIT, 4 * UNIT, UNIT, 0, 0);
		push_triangle(3, 4, -4 * UNIT, 3 * UNIT, -4 * UNIT, 4 * UNIT, 3 * UNIT, -4 * UNIT,
			0, 3 * UNIT, 4 * UNIT, 0, -UNIT, 0);
		enqueue_txn(txn_t'({OP_IGNORED, (TXN_W - OP_W)'(0)}));
		// Extreme coordinates and a steep plane
		push_triangle(4, 5, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 32'h7fffffff,
			32'h7fffffff, 1, 32'h80000000);
		push_query(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_query(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		push_random(150);

		set_normal_min(0);
		push_query(0, 0, 0, 32'h7fffffff, 32'h7fffffff);
		push_random(140);
		set_normal_min(1 << 16);
		push_random(130);
		set_normal_min($urandom_range(20000, 60000));
		push_random(130);

		wait_idle();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
